/* design/per_class_argmax_accuracy_defines.svh */
// Assertion macros used by the checker of this block.
`ifndef PER_CLASS_ARGMAX_ACCURACY_DEFINES_SVH
`define PER_CLASS_ARGMAX_ACCURACY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCAA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCAA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pcaa_pkg.sv */
`default_nettype none
package pcaa_pkg;

    localparam int MAX_CLASSES_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_W    = 7;
    localparam int LABEL_W  = 6;
    localparam int SCORE_W  = 32;
    localparam int CIDX_W   = 6;
    localparam int ACC_W    = 17;
    localparam int ACC_FRAC = 16;
    localparam int SCNT_W   = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [ACC_W-1:0] ACC_ONE         = 17'h10000;
    localparam logic [CFG_W-1:0] NUM_CLASSES_RST = 7'd64;

    // paddr[2] selects the register
    localparam logic REG_NUM_CLASSES = 1'b0;

    localparam logic ACT_SCORE  = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [SCORE_W-1:0] score;
        logic [LABEL_W-1:0]        label;
    } in_item_t;

    typedef struct packed {
        logic [CIDX_W-1:0] class_index;
        logic [ACC_W-1:0]  accuracy;
        logic [SCNT_W-1:0] sample_count;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_RD,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept_score;
        logic accept_finish;
        logic rd_label;
        logic upd_write;
        logic load_div;
        logic div_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sample_end;
        logic div_last;
        logic idx_last;
        logic out_free;
    } ctrl_sts_t;

endpackage
`default_nettype wire

/* design/pcaa_ram.sv */
`default_nettype none
module pcaa_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/pcaa_ctrl.sv */
`default_nettype none
module pcaa_ctrl
    import pcaa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_action,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd,
    output logic           in_stall
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == ACT_FINISH)
                    begin
                        state_next = ST_RD;
                    end
                    else if (sts.sample_end)
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:  state_next = ST_IDLE;
            ST_RD:   state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.idx_last ? ST_IDLE : ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall          = 1'b0;
                cmd.rd_label      = 1'b1;
                cmd.accept_score  = in_valid && (in_action == ACT_SCORE);
                cmd.accept_finish = in_valid && (in_action == ACT_FINISH);
            end
            ST_UPD:  cmd.upd_write = 1'b1;
            ST_RD:   cmd.rd_label  = 1'b0;
            ST_LOAD: cmd.load_div  = 1'b1;
            ST_DIV:  cmd.div_step  = 1'b1;
            ST_EMIT: cmd.emit      = sts.out_free;
            default: cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

/* design/pcaa_dp.sv */
`default_nettype none
module pcaa_dp
    import pcaa_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CFG_W-1:0] num_classes,
    input  wire in_item_t         in_data,
    input  wire ctrl_cmd_t        cmd,
    output ctrl_sts_t             sts,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output out_item_t             out_data
);

    localparam int AW  = $clog2(MAX_CLASSES);
    localparam int CW  = COUNT_WIDTH;
    localparam int RW  = 2 * COUNT_WIDTH;
    localparam int DW  = COUNT_WIDTH + ACC_W;
    localparam int BCW = $clog2(ACC_W);

    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // effective class count, clamped to [1, MAX_CLASSES]
    logic [CFG_W-1:0] n_eff;
    always_comb
    begin
        if (num_classes == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (num_classes > CFG_W'(MAX_CLASSES))
        begin
            n_eff = CFG_W'(MAX_CLASSES);
        end
        else
        begin
            n_eff = num_classes;
        end
    end

    // ---- running argmax ----
    logic signed [SCORE_W-1:0] best_score_reg;
    logic [AW-1:0]             best_class_reg;
    logic [AW-1:0]             pos_reg;
    logic [AW-1:0]             best_class_next;
    logic                      sample_end;

    always_comb
    begin
        if (pos_reg == '0)
        begin
            best_class_next = '0;
        end
        else if (in_data.score > best_score_reg)
        begin
            best_class_next = pos_reg;
        end
        else
        begin
            best_class_next = best_class_reg;
        end
    end

    assign sample_end = (CFG_W'(pos_reg) + CFG_W'(1)) >= n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            best_class_reg <= '0;
            best_score_reg <= '0;
        end
        else if (cmd.accept_finish)
        begin
            pos_reg        <= '0;
            best_class_reg <= '0;
            best_score_reg <= '0;
        end
        else if (cmd.accept_score)
        begin
            best_class_reg <= best_class_next;
            if ((pos_reg == '0) || (in_data.score > best_score_reg))
            begin
                best_score_reg <= in_data.score;
            end
            pos_reg <= sample_end ? '0 : pos_reg + AW'(1);
        end
    end

    // ---- counter update at sample end ----
    logic [AW-1:0] upd_addr_reg;
    logic          upd_en_reg;
    logic          upd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept_score && sample_end)
        begin
            upd_addr_reg <= in_data.label[AW-1:0];
            upd_en_reg   <= CFG_W'(in_data.label) < n_eff;
            upd_hit_reg  <= LABEL_W'(best_class_next) == in_data.label;
        end
    end

    // counter RAM: {correct, count} per class; entries without a valid bit read as zero
    logic [MAX_CLASSES-1:0] valid_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          ram_raddr;
    logic [RW-1:0]          ram_rdata;
    logic [RW-1:0]          ram_wdata;
    logic                   ram_we;
    logic [CW-1:0]          old_cor;
    logic [CW-1:0]          old_cnt;
    logic                   rd_valid;
    logic                   idx_last;

    assign ram_raddr = cmd.rd_label ? in_data.label[AW-1:0] : idx_reg;
    assign rd_valid  = cmd.upd_write ? valid_reg[upd_addr_reg] : valid_reg[idx_reg];
    assign old_cor   = rd_valid ? ram_rdata[RW-1:CW] : '0;
    assign old_cnt   = rd_valid ? ram_rdata[CW-1:0]  : '0;

    assign ram_we = cmd.upd_write && upd_en_reg;
    always_comb
    begin
        ram_wdata[CW-1:0] = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + CW'(1);
        if (upd_hit_reg && (old_cor != CNT_MAX))
        begin
            ram_wdata[RW-1:CW] = old_cor + CW'(1);
        end
        else
        begin
            ram_wdata[RW-1:CW] = old_cor;
        end
    end

    pcaa_ram
    #(
        .WIDTH (RW),
        .DEPTH (MAX_CLASSES)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (upd_addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_last = (CFG_W'(idx_reg) + CFG_W'(1)) == n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.emit && idx_last)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[upd_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_finish)
        begin
            idx_reg <= '0;
        end
        else if (cmd.emit)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // ---- restoring divider, one quotient bit per cycle ----
    // dividend = correct * 2^16 + count / 2; quotient fits 17 bits since correct <= count
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    rem_reg;
    logic [ACC_W-1:0] dvd_reg;
    logic [ACC_W-1:0] q_reg;
    logic [BCW-1:0]   bit_cnt_reg;
    logic [DW-1:0]    dividend;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             q_bit;

    assign dividend = {1'b0, old_cor, {ACC_FRAC{1'b0}}} + DW'(old_cnt >> 1);
    assign trial    = {rem_reg, dvd_reg[ACC_W-1]};
    assign diff     = trial - {1'b0, cnt_reg};
    assign q_bit    = trial >= {1'b0, cnt_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            cnt_reg     <= old_cnt;
            rem_reg     <= dividend[DW-1:ACC_W];
            dvd_reg     <= dividend[ACC_W-1:0];
            q_reg       <= '0;
            bit_cnt_reg <= BCW'(ACC_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= q_bit ? diff[CW-1:0] : trial[CW-1:0];
            dvd_reg     <= {dvd_reg[ACC_W-2:0], 1'b0};
            q_reg       <= {q_reg[ACC_W-2:0], q_bit};
            bit_cnt_reg <= bit_cnt_reg - BCW'(1);
        end
    end

    // ---- output register ----
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic [ACC_W-1:0] acc;

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            acc = '0;
        end
        else if (q_reg > ACC_ONE)
        begin
            acc = ACC_ONE;
        end
        else
        begin
            acc = q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.class_index  <= CIDX_W'(idx_reg);
            out_data_reg.accuracy     <= acc;
            out_data_reg.sample_count <= SCNT_W'(cnt_reg);
            out_data_reg.last         <= idx_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.sample_end = sample_end;
    assign sts.div_last   = bit_cnt_reg == '0;
    assign sts.idx_last   = idx_last;
    assign sts.out_free   = !out_valid_reg || !out_stall;

endmodule
`default_nettype wire

/* design/per_class_argmax_accuracy.sv */
`default_nettype none
// Per-class top-1 accuracy. Score beats (action 0) are taken one per cycle, but
// the last score of a sample stalls the input for an update state, since the
// class counters sit in a RAM with a registered read and are updated by
// read-modify-write. A finish beat (action 1) walks the classes 0 ..
// num_classes-1: each row takes a RAM read, operand load, a 17-step restoring
// divider producing one quotient bit per cycle and output load, and waits while
// out_stall holds the output register; input is stalled for the whole walk.
// After the last row the counters read as zero at once (per-entry valid bits),
// so there is no clearing pass after reset or finish. num_classes of 0 acts as
// 1, above MAX_CLASSES as MAX_CLASSES; labels >= the result count nothing.
module per_class_argmax_accuracy
    import pcaa_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_item_t               out_data
);

    logic [CFG_W-1:0] num_classes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= NUM_CLASSES_RST;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_NUM_CLASSES))
        begin
            num_classes_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_CLASSES) ? PDATA_W'(num_classes_reg) : '0;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    pcaa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    pcaa_dp
    #(
        .MAX_CLASSES (MAX_CLASSES),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_classes (num_classes_reg),
        .in_data     (in_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule
`default_nettype wire

/* design/per_class_argmax_accuracy_chk.sv */
`default_nettype none
`include "per_class_argmax_accuracy_defines.svh"
module per_class_argmax_accuracy_chk
    import pcaa_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    logic out_held;
    logic fin_beat;
    logic acc_ok;

    assign out_held = out_valid && out_stall;
    assign fin_beat = in_valid && !in_stall && (in_data.action == ACT_FINISH);
    assign acc_ok   = (out_data.accuracy <= ACC_ONE)
                   && ((out_data.sample_count != '0) || (out_data.accuracy == '0));

    // a held result beat keeps its payload
    `PCAA_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "result beat changed")

    // the finish walk blocks the input
    `PCAA_ASSERT_NEXT(a_finish_stalls, fin_beat, in_stall, "finish beat did not stall input")

    // rows are only loaded during the walk
    `PCAA_ASSERT_NOW(a_row_in_walk, $rose(out_valid), $past(in_stall), "row outside walk")

    // accuracy never above 1.0, and zero for an empty class
    `PCAA_ASSERT_NOW(a_acc_range, out_valid, acc_ok, "accuracy out of range")

endmodule

bind per_class_argmax_accuracy per_class_argmax_accuracy_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
